// ===== src/midi_stream_message_parser_defines.svh =====
// Assertion macros for the MIDI stream message parser.
`ifndef MIDI_STREAM_MESSAGE_PARSER_DEFINES_SVH
`define MIDI_STREAM_MESSAGE_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF

// Checked on every clock edge outside reset.
`define MSMP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MSMP_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MSMP_ASSERT(label, prop, msg)
`define MSMP_ASSERT_RST(label, prop, msg)

`endif

`endif

// ===== src/msmp_pkg.sv =====
// Types, codes and constants shared by the MIDI stream message parser.
package msmp_pkg;

    localparam int PORTS_DEF = 4;
    localparam logic [7:0] SYSEX_LIMIT_RST = 8'd200;

    // Status bytes and running status codes
    localparam logic [7:0] ST_NOTE_OFF   = 8'h80;
    localparam logic [7:0] ST_NOTE_ON    = 8'h90;
    localparam logic [7:0] ST_KEY_PRESS  = 8'hA0;
    localparam logic [7:0] ST_CTRL       = 8'hB0;
    localparam logic [7:0] ST_PROG       = 8'hC0;
    localparam logic [7:0] ST_CHAN_PRESS = 8'hD0;
    localparam logic [7:0] ST_BEND       = 8'hE0;
    localparam logic [7:0] ST_SYSEX      = 8'hF0;
    localparam logic [7:0] ST_SONG_POS   = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL   = 8'hF3;
    localparam logic [7:0] ST_RT_FIRST   = 8'hF8;
    localparam logic [7:0] ST_CLOCK      = 8'hF8;
    localparam logic [7:0] ST_START      = 8'hFA;
    localparam logic [7:0] ST_CONT       = 8'hFB;
    localparam logic [7:0] ST_STOP       = 8'hFC;
    localparam logic [7:0] ST_SENSE      = 8'hFE;
    localparam logic [7:0] ST_RESET      = 8'hFF;
    localparam logic [7:0] RSTAT_CLEAR   = 8'h00;
    localparam logic [7:0] RSTAT_NONE    = 8'hFF;

    localparam logic [6:0] CTRL_MODE_FIRST = 7'd120;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_DATA0 = 4'b0010,
        PH_DATA1 = 4'b0100,
        PH_SYSEX = 4'b1000
    } phase_t;

    typedef enum logic [4:0] {
        KIND_NOTE_OFF       = 5'd0,
        KIND_NOTE_ON        = 5'd1,
        KIND_KEY_PRESS      = 5'd2,
        KIND_CTRL           = 5'd3,
        KIND_MODE_SOUND_OFF = 5'd4,
        KIND_MODE_RESET_CC  = 5'd5,
        KIND_MODE_LOCAL     = 5'd6,
        KIND_MODE_NOTES_OFF = 5'd7,
        KIND_MODE_OMNI_OFF  = 5'd8,
        KIND_MODE_OMNI_ON   = 5'd9,
        KIND_MODE_MONO      = 5'd10,
        KIND_MODE_POLY      = 5'd11,
        KIND_PROG           = 5'd12,
        KIND_CHAN_PRESS     = 5'd13,
        KIND_BEND           = 5'd14,
        KIND_SONG_POS       = 5'd15,
        KIND_SONG_SEL       = 5'd16,
        KIND_CLOCK          = 5'd17,
        KIND_START          = 5'd18,
        KIND_CONT           = 5'd19,
        KIND_STOP           = 5'd20,
        KIND_SENSE          = 5'd21,
        KIND_RESET          = 5'd22,
        KIND_SYSEX_BYTE     = 5'd23,
        KIND_SYSEX_END      = 5'd24
    } kind_t;

    typedef struct packed {
        logic [1:0] port;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  port_out;
        logic [4:0]  kind;
        logic [3:0]  channel;
        logic [7:0]  number;
        logic [13:0] value;
    } out_item_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] rstat;
        logic       no_chan;
        logic [3:0] chan;
        logic [6:0] first_data;
        logic [7:0] sysex_count;
    } port_state_t;

    localparam port_state_t PORT_STATE_RST = '{
        phase:       PH_IDLE,
        rstat:       RSTAT_NONE,
        no_chan:     1'b0,
        chan:        4'd0,
        first_data:  7'd0,
        sysex_count: 8'd0
    };

endpackage

// ===== src/midi_stream_message_parser.sv =====
// Top level of the multiport MIDI stream message parser.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    in_data   (port, rx_byte)
//  out      output     out_valid / out_stall  out_data  (port_out, kind, channel, number, value)
//  cfg      input      cfg_valid / cfg_ready  cfg_data  (sysex_limit)
//
// One byte per cycle while in_stall is low; an accepted byte is held in the input register
// and its event is then registered in the result register, from which it can be taken.
// Per-port parser state sits in flip-flops and is updated when the byte leaves
// the input register, so the next byte of the same port sees it at once.
// out_stall holds the result register; in_stall rises only when the byte in the
// input register has an event and the result register cannot take it.
// Reset puts every port idle with no running status, empties both registers and
// sets the sysex limit to 200.
`include "midi_stream_message_parser_defines.svh"

module midi_stream_message_parser #(
    parameter int PORTS = msmp_pkg::PORTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  msmp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output msmp_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);

    localparam int PORT_IDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;

    logic                  s1_valid_reg;
    msmp_pkg::in_item_t    s1_item_reg;
    logic                  out_valid_reg;
    msmp_pkg::out_item_t   out_item_reg;
    logic [7:0]            sysex_limit_reg;
    msmp_pkg::port_state_t state_reg [PORTS];

    logic [PORT_IDX_W-1:0] s1_idx;
    logic                  in_range;
    msmp_pkg::port_state_t cur_state;
    msmp_pkg::port_state_t state_next;
    logic                  dec_valid;
    msmp_pkg::out_item_t   dec_ev;
    logic                  ev_valid;
    logic                  out_free;
    logic                  s1_adv;
    logic                  in_accept;

    assign s1_idx    = PORT_IDX_W'(s1_item_reg.port);
    assign in_range  = 32'(s1_item_reg.port) < PORTS;
    assign cur_state = state_reg[s1_idx];

    msmp_decode u_decode (
        .cur         (cur_state),
        .port        (s1_item_reg.port),
        .rx_byte     (s1_item_reg.rx_byte),
        .sysex_limit (sysex_limit_reg),
        .nxt         (state_next),
        .ev_valid    (dec_valid),
        .ev          (dec_ev)
    );

    assign ev_valid  = dec_valid && in_range;
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && (!ev_valid || out_free);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv && ev_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg <= in_data;
        end
        if (s1_adv && ev_valid)
        begin
            out_item_reg <= dec_ev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sysex_limit_reg <= msmp_pkg::SYSEX_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            sysex_limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PORTS; i++)
            begin
                state_reg[i] <= msmp_pkg::PORT_STATE_RST;
            end
        end
        else
        begin
            for (int i = 0; i < PORTS; i++)
            begin
                if (s1_adv && in_range && (s1_idx == PORT_IDX_W'(i)))
                begin
                    state_reg[i] <= state_next;
                end
            end
        end
    end

    `MSMP_ASSERT(a_event_reaches_output, s1_adv && ev_valid |=> out_valid_reg, "decoded event was not registered")
    `MSMP_ASSERT(a_stall_needs_item, in_stall |-> s1_valid_reg && ev_valid && out_valid_reg, "input stalled without a blocked event")
    `MSMP_ASSERT(a_sysex_status, s1_valid_reg && in_range && (cur_state.phase == msmp_pkg::PH_SYSEX) |-> (cur_state.rstat == msmp_pkg::ST_SYSEX), "sysex phase without sysex status")
    `MSMP_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid_reg && !s1_valid_reg, "pipeline not empty after reset")

endmodule

// ===== src/msmp_decode.sv =====
// Per-byte decode: next port state and the event, if any, for one MIDI byte.
module msmp_decode (
    input  msmp_pkg::port_state_t cur,
    input  logic [1:0]            port,
    input  logic [7:0]            rx_byte,
    input  logic [7:0]            sysex_limit,
    output msmp_pkg::port_state_t nxt,
    output logic                  ev_valid,
    output msmp_pkg::out_item_t   ev
);

    logic [6:0]          d;
    logic                short_msg;
    logic                msg_done;
    logic [6:0]          msg_d0;
    logic [6:0]          msg_d1;
    logic                msg_valid;
    msmp_pkg::out_item_t msg_ev;

    assign d = rx_byte[6:0];
    assign short_msg = (cur.rstat == msmp_pkg::ST_SONG_SEL) ||
                       (cur.rstat == msmp_pkg::ST_PROG) ||
                       (cur.rstat == msmp_pkg::ST_CHAN_PRESS);
    assign msg_d0 = (cur.phase == msmp_pkg::PH_DATA0) ? d : cur.first_data;
    assign msg_d1 = (cur.phase == msmp_pkg::PH_DATA0) ? 7'd0 : d;
    assign msg_done = !rx_byte[7] &&
                      (((cur.phase == msmp_pkg::PH_DATA0) && short_msg) ||
                       (cur.phase == msmp_pkg::PH_DATA1));

    // Complete message from running status and its data bytes
    always_comb
    begin
        msg_valid       = 1'b1;
        msg_ev          = '0;
        msg_ev.port_out = port;
        msg_ev.channel  = cur.chan;
        msg_ev.number   = {1'b0, msg_d0};
        msg_ev.value    = {7'd0, msg_d1};
        unique case (cur.rstat)
            msmp_pkg::ST_SONG_POS:
            begin
                msg_ev.kind    = msmp_pkg::KIND_SONG_POS;
                msg_ev.channel = 4'd0;
                msg_ev.number  = 8'd0;
                msg_ev.value   = {msg_d1, msg_d0};
            end
            msmp_pkg::ST_SONG_SEL:
            begin
                msg_ev.kind    = msmp_pkg::KIND_SONG_SEL;
                msg_ev.channel = 4'd0;
                msg_ev.value   = 14'd0;
            end
            msmp_pkg::ST_NOTE_OFF:
            begin
                msg_ev.kind = msmp_pkg::KIND_NOTE_OFF;
            end
            msmp_pkg::ST_NOTE_ON:
            begin
                // velocity zero is a release
                msg_ev.kind = (msg_d1 == 7'd0) ? msmp_pkg::KIND_NOTE_OFF
                                               : msmp_pkg::KIND_NOTE_ON;
            end
            msmp_pkg::ST_KEY_PRESS:
            begin
                msg_ev.kind = msmp_pkg::KIND_KEY_PRESS;
            end
            msmp_pkg::ST_CTRL:
            begin
                if (msg_d0 < msmp_pkg::CTRL_MODE_FIRST)
                begin
                    msg_ev.kind = msmp_pkg::KIND_CTRL;
                end
                else
                begin
                    // controllers 120..127 differ only in the low three bits
                    msg_ev.kind = 5'(msmp_pkg::KIND_MODE_SOUND_OFF) + 5'(msg_d0[2:0]);
                end
            end
            msmp_pkg::ST_PROG:
            begin
                msg_ev.kind   = msmp_pkg::KIND_PROG;
                msg_ev.number = 8'd0;
                msg_ev.value  = {7'd0, msg_d0};
            end
            msmp_pkg::ST_CHAN_PRESS:
            begin
                msg_ev.kind   = msmp_pkg::KIND_CHAN_PRESS;
                msg_ev.number = 8'd0;
                msg_ev.value  = {7'd0, msg_d0};
            end
            msmp_pkg::ST_BEND:
            begin
                msg_ev.kind   = msmp_pkg::KIND_BEND;
                msg_ev.number = 8'd0;
                msg_ev.value  = {msg_d1, msg_d0};
            end
            default:
            begin
                msg_valid = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        nxt         = cur;
        ev_valid    = 1'b0;
        ev          = '0;
        ev.port_out = port;
        if (rx_byte[7])
        begin
            if (rx_byte >= msmp_pkg::ST_RT_FIRST)
            begin
                // realtime leaves the parser alone; system reset does not
                ev_valid = 1'b1;
                unique case (rx_byte)
                    msmp_pkg::ST_CLOCK: ev.kind = msmp_pkg::KIND_CLOCK;
                    msmp_pkg::ST_START: ev.kind = msmp_pkg::KIND_START;
                    msmp_pkg::ST_CONT:  ev.kind = msmp_pkg::KIND_CONT;
                    msmp_pkg::ST_STOP:  ev.kind = msmp_pkg::KIND_STOP;
                    msmp_pkg::ST_SENSE: ev.kind = msmp_pkg::KIND_SENSE;
                    msmp_pkg::ST_RESET:
                    begin
                        ev.kind     = msmp_pkg::KIND_RESET;
                        nxt.no_chan = 1'b1;
                        nxt.rstat   = msmp_pkg::RSTAT_CLEAR;
                        nxt.phase   = msmp_pkg::PH_IDLE;
                    end
                    default:            ev_valid = 1'b0;
                endcase
            end
            else
            begin
                if (cur.phase == msmp_pkg::PH_SYSEX)
                begin
                    ev_valid = 1'b1;
                    ev.kind  = msmp_pkg::KIND_SYSEX_END;
                    ev.value = {6'd0, cur.sysex_count};
                end
                if (rx_byte == msmp_pkg::ST_SYSEX)
                begin
                    nxt.sysex_count = 8'd0;
                    nxt.no_chan     = 1'b1;
                    nxt.rstat       = msmp_pkg::ST_SYSEX;
                    nxt.phase       = msmp_pkg::PH_SYSEX;
                end
                else if ((rx_byte == msmp_pkg::ST_SONG_POS) ||
                         (rx_byte == msmp_pkg::ST_SONG_SEL))
                begin
                    nxt.no_chan = 1'b1;
                    nxt.rstat   = rx_byte;
                    nxt.phase   = msmp_pkg::PH_DATA0;
                end
                else if (rx_byte >= msmp_pkg::ST_SYSEX)
                begin
                    nxt.no_chan = 1'b1;
                    nxt.rstat   = msmp_pkg::RSTAT_CLEAR;
                    nxt.phase   = msmp_pkg::PH_IDLE;
                end
                else
                begin
                    nxt.no_chan = 1'b0;
                    nxt.chan    = rx_byte[3:0];
                    nxt.rstat   = {rx_byte[7:4], 4'h0};
                    nxt.phase   = msmp_pkg::PH_DATA0;
                end
            end
        end
        else
        begin
            unique case (cur.phase)
                msmp_pkg::PH_DATA0:
                begin
                    nxt.first_data = d;
                    if (!short_msg)
                    begin
                        nxt.phase = msmp_pkg::PH_DATA1;
                    end
                end
                msmp_pkg::PH_SYSEX:
                begin
                    if (cur.sysex_count < sysex_limit)
                    begin
                        ev_valid        = 1'b1;
                        ev.kind         = msmp_pkg::KIND_SYSEX_BYTE;
                        ev.number       = cur.sysex_count;
                        ev.value        = {7'd0, d};
                        nxt.sysex_count = cur.sysex_count + 8'd1;
                    end
                end
                default:
                begin
                end
            endcase
            if (msg_done)
            begin
                ev_valid  = msg_valid;
                ev        = msg_ev;
                nxt.phase = cur.no_chan ? msmp_pkg::PH_IDLE : msmp_pkg::PH_DATA0;
            end
        end
    end

endmodule

// ===== verif/midi_stream_message_parser_tb.sv =====
// Self-checking testbench for the multiport MIDI stream message parser.
`timescale 1ns / 1ps

module midi_stream_message_parser_tb;

    // Status bytes that the package does not name
    localparam logic [7:0] ST_MTC_QFRAME = 8'hF1;
    localparam logic [7:0] ST_UNDEF_F4   = 8'hF4;
    localparam logic [7:0] ST_UNDEF_F5   = 8'hF5;
    localparam logic [7:0] ST_TUNE_REQ   = 8'hF6;
    localparam logic [7:0] ST_EOX        = 8'hF7;
    localparam logic [7:0] RT_UNDEF_F9   = 8'hF9;
    localparam logic [7:0] RT_UNDEF_FD   = 8'hFD;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    msmp_pkg::in_item_t   in_data;
    logic                 out_valid;
    logic                 out_stall;
    msmp_pkg::out_item_t  out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [7:0]           cfg_data;

    // Shadow of the parser: per-port state and the sysex limit
    msmp_pkg::port_state_t port_st [msmp_pkg::PORTS_DEF];
    logic [7:0]            limit_shadow;

    msmp_pkg::out_item_t   pending_events [$];
    msmp_pkg::out_item_t   oldest_event;

    int          errors = 0;
    int          bytes_sent = 0;
    int          events_checked = 0;
    int          blocked_cycles = 0;
    int          stall_hold = 0;
    bit          idle_off = 1'b0;

    midi_stream_message_parser uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic msmp_pkg::out_item_t midi_event(input logic [1:0] p,
                                                       input logic [4:0] k,
                                                       input logic [3:0] ch,
                                                       input logic [7:0] num,
                                                       input logic [13:0] val);
        msmp_pkg::out_item_t ev;
        ev.port_out = p;
        ev.kind     = k;
        ev.channel  = ch;
        ev.number   = num;
        ev.value    = val;
        return ev;
    endfunction

    // Complete message under the port's running status
    function automatic bit voice_event(input logic [1:0] p, input logic [6:0] d0,
                                       input logic [6:0] d1,
                                       output msmp_pkg::out_item_t ev);
        logic [3:0] ch;
        ch = port_st[p].chan;
        ev = '0;
        case (port_st[p].rstat)
            msmp_pkg::ST_SONG_POS:
                ev = midi_event(p, msmp_pkg::KIND_SONG_POS, 4'd0, 8'd0, {d1, d0});
            msmp_pkg::ST_SONG_SEL:
                ev = midi_event(p, msmp_pkg::KIND_SONG_SEL, 4'd0, {1'b0, d0}, 14'd0);
            msmp_pkg::ST_NOTE_OFF:
                ev = midi_event(p, msmp_pkg::KIND_NOTE_OFF, ch, {1'b0, d0}, {7'd0, d1});
            msmp_pkg::ST_NOTE_ON:
            begin
                if (d1 == 7'd0)
                    ev = midi_event(p, msmp_pkg::KIND_NOTE_OFF, ch, {1'b0, d0}, 14'd0);
                else
                    ev = midi_event(p, msmp_pkg::KIND_NOTE_ON, ch, {1'b0, d0}, {7'd0, d1});
            end
            msmp_pkg::ST_KEY_PRESS:
                ev = midi_event(p, msmp_pkg::KIND_KEY_PRESS, ch, {1'b0, d0}, {7'd0, d1});
            msmp_pkg::ST_CTRL:
            begin
                if (d0 < msmp_pkg::CTRL_MODE_FIRST)
                    ev = midi_event(p, msmp_pkg::KIND_CTRL, ch, {1'b0, d0}, {7'd0, d1});
                else
                    ev = midi_event(p, 5'(msmp_pkg::KIND_MODE_SOUND_OFF) +
                                       5'(d0 - msmp_pkg::CTRL_MODE_FIRST),
                                    ch, {1'b0, d0}, {7'd0, d1});
            end
            msmp_pkg::ST_PROG:
                ev = midi_event(p, msmp_pkg::KIND_PROG, ch, 8'd0, {7'd0, d0});
            msmp_pkg::ST_CHAN_PRESS:
                ev = midi_event(p, msmp_pkg::KIND_CHAN_PRESS, ch, 8'd0, {7'd0, d0});
            msmp_pkg::ST_BEND:
                ev = midi_event(p, msmp_pkg::KIND_BEND, ch, 8'd0, {d1, d0});
            default:       return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Updates the shadow state for one byte; returns 1 when the byte yields an event
    function automatic bit decode_midi_byte(input logic [1:0] p, input logic [7:0] b,
                                            output msmp_pkg::out_item_t ev);
        bit hit;
        hit = 1'b0;
        ev  = '0;
        if (int'(p) >= msmp_pkg::PORTS_DEF)
            return 1'b0;
        if (b[7])
        begin
            if (b >= msmp_pkg::ST_RT_FIRST)
            begin
                hit = 1'b1;
                case (b)
                    msmp_pkg::ST_CLOCK:
                        ev = midi_event(p, msmp_pkg::KIND_CLOCK, 4'd0, 8'd0, 14'd0);
                    msmp_pkg::ST_START:
                        ev = midi_event(p, msmp_pkg::KIND_START, 4'd0, 8'd0, 14'd0);
                    msmp_pkg::ST_CONT:
                        ev = midi_event(p, msmp_pkg::KIND_CONT, 4'd0, 8'd0, 14'd0);
                    msmp_pkg::ST_STOP:
                        ev = midi_event(p, msmp_pkg::KIND_STOP, 4'd0, 8'd0, 14'd0);
                    msmp_pkg::ST_SENSE:
                        ev = midi_event(p, msmp_pkg::KIND_SENSE, 4'd0, 8'd0, 14'd0);
                    msmp_pkg::ST_RESET:
                    begin
                        port_st[p].no_chan = 1'b1;
                        port_st[p].rstat   = msmp_pkg::RSTAT_CLEAR;
                        port_st[p].phase   = msmp_pkg::PH_IDLE;
                        ev = midi_event(p, msmp_pkg::KIND_RESET, 4'd0, 8'd0, 14'd0);
                    end
                    default:  hit = 1'b0;
                endcase
                return hit;
            end
            // any other status closes an open sysex
            if (port_st[p].phase == msmp_pkg::PH_SYSEX)
            begin
                ev  = midi_event(p, msmp_pkg::KIND_SYSEX_END, 4'd0, 8'd0,
                                 {6'd0, port_st[p].sysex_count});
                hit = 1'b1;
            end
            if (b == msmp_pkg::ST_SYSEX)
            begin
                port_st[p].sysex_count = 8'd0;
                port_st[p].no_chan     = 1'b1;
                port_st[p].rstat       = msmp_pkg::ST_SYSEX;
                port_st[p].phase       = msmp_pkg::PH_SYSEX;
            end
            else if (b == msmp_pkg::ST_SONG_POS || b == msmp_pkg::ST_SONG_SEL)
            begin
                port_st[p].no_chan = 1'b1;
                port_st[p].rstat   = b;
                port_st[p].phase   = msmp_pkg::PH_DATA0;
            end
            else if (b >= msmp_pkg::ST_SYSEX)
            begin
                port_st[p].no_chan = 1'b1;
                port_st[p].rstat   = msmp_pkg::RSTAT_CLEAR;
                port_st[p].phase   = msmp_pkg::PH_IDLE;
            end
            else
            begin
                port_st[p].no_chan = 1'b0;
                port_st[p].chan    = b[3:0];
                port_st[p].rstat   = {b[7:4], 4'd0};
                port_st[p].phase   = msmp_pkg::PH_DATA0;
            end
            return hit;
        end
        case (port_st[p].phase)
            msmp_pkg::PH_DATA0:
            begin
                port_st[p].first_data = b[6:0];
                if (port_st[p].rstat == msmp_pkg::ST_SONG_SEL ||
                    port_st[p].rstat == msmp_pkg::ST_PROG ||
                    port_st[p].rstat == msmp_pkg::ST_CHAN_PRESS)
                begin
                    hit = voice_event(p, b[6:0], 7'd0, ev);
                    port_st[p].phase = port_st[p].no_chan ? msmp_pkg::PH_IDLE
                                                          : msmp_pkg::PH_DATA0;
                end
                else
                    port_st[p].phase = msmp_pkg::PH_DATA1;
            end
            msmp_pkg::PH_DATA1:
            begin
                hit = voice_event(p, port_st[p].first_data, b[6:0], ev);
                port_st[p].phase = port_st[p].no_chan ? msmp_pkg::PH_IDLE
                                                      : msmp_pkg::PH_DATA0;
            end
            msmp_pkg::PH_SYSEX:
            begin
                // bytes past the limit are dropped silently
                if (port_st[p].sysex_count < limit_shadow)
                begin
                    ev = midi_event(p, msmp_pkg::KIND_SYSEX_BYTE, 4'd0,
                                    port_st[p].sysex_count, {6'd0, b});
                    port_st[p].sysex_count++;
                    hit = 1'b1;
                end
            end
            default: ;
        endcase
        return hit;
    endfunction

    task automatic send_byte(input logic [1:0] p, input logic [7:0] b);
        int                  gap;
        msmp_pkg::out_item_t ev;
        gap = idle_off ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {p, b};
        do
        begin
            @(posedge clk);
            if (in_stall)
                blocked_cycles++;
        end
        while (in_stall);
        bytes_sent++;
        if (decode_midi_byte(p, b, ev))
            pending_events.push_back(ev);
    endtask

    // Sends n bytes on one port, most significant byte first
    task automatic send_msg(input logic [1:0] p, input logic [31:0] bytes, input int n);
        int i;
        for (i = n - 1; i >= 0; i--)
            send_byte(p, bytes[8 * i +: 8]);
    endtask

    task automatic maybe_realtime(input logic [1:0] p);
        if ($urandom_range(0, 9) == 0)
            send_byte(p, 8'($urandom_range(msmp_pkg::ST_RT_FIRST, msmp_pkg::ST_SENSE)));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        // bytes with no event may still sit in the pipeline
        repeat (4) @(posedge clk);
    endtask

    task automatic write_sysex_limit(input logic [7:0] lim);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_shadow = lim;
    endtask

    task automatic test_channel_voice();
        send_msg(2'd0, {msmp_pkg::ST_NOTE_ON, 8'h00, 8'h7F}, 3);
        send_msg(2'd0, {8'h7F, 8'h00}, 2);                      // velocity zero -> note off
        send_msg(2'd1, {msmp_pkg::ST_NOTE_OFF | 8'h0F, 8'h7F, 8'h40}, 3);
        send_msg(2'd2, {msmp_pkg::ST_KEY_PRESS | 8'h03, 8'h10, msmp_pkg::ST_CLOCK, 8'h20}, 4);
        send_msg(2'd3, {msmp_pkg::ST_CTRL | 8'h04, 8'h77, 8'h01, 8'h78}, 4);
        send_msg(2'd3, {msmp_pkg::ST_SENSE, 8'h7F, 8'h7F, 8'h00}, 4); // mode ctrl 120, 127
        send_msg(2'd0, {msmp_pkg::ST_PROG | 8'h05, 8'h7F, 8'h00}, 3);
        send_msg(2'd0, {msmp_pkg::ST_CHAN_PRESS | 8'h06, 8'h33}, 2);
        send_msg(2'd1, {msmp_pkg::ST_BEND | 8'h07, 8'h7F, 8'h7F}, 3);
    endtask

    task automatic test_system_messages();
        send_msg(2'd2, {msmp_pkg::ST_SONG_POS, 8'h01, 8'h02, msmp_pkg::ST_SONG_SEL}, 4);
        send_msg(2'd2, {8'h05, 8'h40}, 2);                      // second byte is stray
        send_msg(2'd1, {msmp_pkg::ST_START, msmp_pkg::ST_CONT, msmp_pkg::ST_STOP,
                        RT_UNDEF_F9}, 4);
        send_byte(2'd1, RT_UNDEF_FD);
        send_msg(2'd3, {ST_MTC_QFRAME, 8'h10, ST_UNDEF_F4}, 3);
        send_msg(2'd3, {ST_UNDEF_F5, ST_TUNE_REQ}, 2);
        send_msg(2'd0, {ST_EOX, 8'h11}, 2);                     // end of sysex with none open
    endtask

    task automatic test_sysex_framing();
        send_msg(2'd1, {msmp_pkg::ST_SYSEX, 8'h00, msmp_pkg::ST_CONT, 8'h7F}, 4);
        send_byte(2'd1, ST_EOX);
        // reset drops the open sysex
        send_msg(2'd0, {msmp_pkg::ST_SYSEX, 8'h11, msmp_pkg::ST_RESET, 8'h22}, 4);
        send_msg(2'd2, {msmp_pkg::ST_SYSEX, 8'h01, msmp_pkg::ST_SYSEX, 8'h02}, 4);
        send_msg(2'd2, {msmp_pkg::ST_NOTE_ON | 8'h01, 8'h30, 8'h50}, 3);
    endtask

    task automatic test_sysex_limit();
        int i;
        write_sysex_limit(8'd1);
        send_msg(2'd3, {msmp_pkg::ST_SYSEX, 8'h0A, 8'h0B, 8'h0C}, 4);
        send_byte(2'd3, ST_EOX);
        write_sysex_limit(8'd254);
        idle_off = 1'b1;
        send_byte(2'd2, msmp_pkg::ST_SYSEX);
        for (i = 0; i < 256; i++)
            send_byte(2'd2, 8'($urandom_range(0, 127)));
        send_byte(2'd2, ST_EOX);
        idle_off = 1'b0;
    endtask

    task automatic send_random_message();
        logic [1:0] p;
        logic [7:0] st;
        logic [7:0] d;
        int         sel;
        int         len;
        p   = 2'($urandom_range(0, 3));
        sel = $urandom_range(0, 99);
        if (sel < 45)
        begin
            st = {4'($urandom_range(8, 14)), 4'($urandom)};
            send_byte(p, st);
            repeat ($urandom_range(1, 3))
            begin
                d = 8'($urandom_range(0, 127));
                if (st[7:4] == msmp_pkg::ST_CTRL[7:4] && $urandom_range(0, 3) == 0)
                    d = 8'($urandom_range(msmp_pkg::CTRL_MODE_FIRST, 127));
                send_byte(p, d);
                maybe_realtime(p);
                if (st[7:4] != msmp_pkg::ST_PROG[7:4] &&
                    st[7:4] != msmp_pkg::ST_CHAN_PRESS[7:4])
                    send_byte(p, ($urandom_range(0, 4) == 0) ? 8'd0
                                                             : 8'($urandom_range(0, 127)));
            end
        end
        else if (sel < 55)
        begin
            if ($urandom_range(0, 1) == 1)
                send_msg(p, {msmp_pkg::ST_SONG_POS, 8'($urandom_range(0, 127)),
                             8'($urandom_range(0, 127))}, 3);
            else
                send_msg(p, {msmp_pkg::ST_SONG_SEL, 8'($urandom_range(0, 127))}, 2);
        end
        else if (sel < 75)
        begin
            send_byte(p, msmp_pkg::ST_SYSEX);
            len = $urandom_range(0, (limit_shadow < 10) ? int'(limit_shadow) + 3 : 12);
            repeat (len)
            begin
                send_byte(p, 8'($urandom_range(0, 127)));
                maybe_realtime(p);
            end
            case ($urandom_range(0, 3))
                0, 1:    send_byte(p, ST_EOX);
                2:       send_byte(p, 8'($urandom_range(8'h80, ST_EOX)));
                default: send_byte(p, msmp_pkg::ST_RESET);
            endcase
        end
        else if (sel < 85)
            send_byte(p, 8'($urandom_range(ST_MTC_QFRAME, msmp_pkg::ST_RESET)));
        else
            send_byte(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_traffic(input int n, input logic [7:0] lim, input bit quiet);
        int target;
        write_sysex_limit(lim);
        idle_off = quiet;
        target = bytes_sent + n;
        while (bytes_sent < target)
            send_random_message();
        idle_off = 1'b0;
    endtask

    // Output held off for a long stretch while input keeps coming back to back
    task automatic test_backpressure();
        int i;
        wait_drained();
        idle_off   = 1'b1;
        stall_hold = 80;
        for (i = 0; i < 20; i++)
            send_msg(2'(i % 4), {msmp_pkg::ST_NOTE_ON | 8'(i % 16), 8'(i), 8'(i + 1)}, 3);
        idle_off = 1'b0;
    endtask

    task automatic compare_field(input string field, input logic [13:0] want,
                                 input logic [13:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= 20)
                $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_events.size() == 0)
            begin
                errors++;
                $display("%0t ns: event with none expected, expected nothing, got %p",
                         $time, out_data);
            end
            else
            begin
                oldest_event = pending_events.pop_front();
                events_checked++;
                compare_field("port_out", oldest_event.port_out, out_data.port_out);
                compare_field("kind", oldest_event.kind, out_data.kind);
                compare_field("channel", oldest_event.channel, out_data.channel);
                compare_field("number", oldest_event.number, out_data.number);
                compare_field("value", oldest_event.value, out_data.value);
            end
        end
    end

    initial
    begin : receiver
        int n;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (stall_hold > 0)
            begin
                n = stall_hold;
                stall_hold = 0;
            end
            else
                n = idle_off ? 0 : $urandom_range(0, 6);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        limit_shadow = msmp_pkg::SYSEX_LIMIT_RST;
        foreach (port_st[i])
            port_st[i] = msmp_pkg::PORT_STATE_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_channel_voice();
        test_system_messages();
        test_sysex_framing();
        test_sysex_limit();
        test_random_traffic(30, 8'($urandom_range(1, 8)), 1'b0);
        test_random_traffic(30, msmp_pkg::SYSEX_LIMIT_RST, 1'b1);
        test_random_traffic(30, 8'($urandom_range(1, 254)), 1'b0);
        test_random_traffic(30, 8'd1, 1'b0);
        test_backpressure();
        wait_drained();

        $display("%0d bytes on four ports gave %0d events: voice, mode, system and sysex traffic",
                 bytes_sent, events_checked);
        $display("sysex limits from 1 to 254 used; input held off for %0d cycles",
                 blocked_cycles);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/msmp_pkg.sv
src/msmp_decode.sv
src/midi_stream_message_parser.sv
verif/midi_stream_message_parser_tb.sv
